>>> rtl/rtlpm_pkg.sv
// Shared types and constants of the route table longest prefix match engine.
package rtlpm_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    ReqAdd    = 2'd0,
    ReqDelete = 2'd1,
    ReqLookup = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2,
    StNoRoute  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmSweep,
    FsmEmit
  } fsm_e;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  iface;
    logic [15:0] metric;
  } route_t;

  typedef struct packed {
    logic            valid;
    logic            lookup;
    logic [31:0]     key_addr;
    logic [31:0]     key_mask;
    logic            found;
    logic [IdxW-1:0] idx;
    route_t          data;
  } tok_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    route_t          data;
  } wr_t;

endpackage

>>> rtl/rtlpm_req_if.sv
// Request channel carrying one route table request item.
interface rtlpm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] dest_address;
  logic [31:0] prefix_mask;
  logic [31:0] next_hop;
  logic [3:0]  iface_id;
  logic [15:0] metric;

  modport source (
    output valid, req_type, dest_address, prefix_mask, next_hop, iface_id, metric,
    input  ready
  );
  modport sink (
    input  valid, req_type, dest_address, prefix_mask, next_hop, iface_id, metric,
    output ready
  );
endinterface

>>> rtl/rtlpm_rsp_if.sv
// Response channel carrying one route table result item.
interface rtlpm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] hit_network;
  logic [31:0] hit_mask;
  logic [31:0] hit_gateway;
  logic [3:0]  hit_iface;
  logic [15:0] hit_metric;

  modport source (
    output valid, status, hit_network, hit_mask, hit_gateway, hit_iface, hit_metric,
    input  ready
  );
  modport sink (
    input  valid, status, hit_network, hit_mask, hit_gateway, hit_iface, hit_metric,
    output ready
  );
endinterface

>>> rtl/rtlpm_cell.sv
// One route table slot: holds an entry and updates the search token passing through it.
module rtlpm_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rtlpm_pkg::IdxW-1:0]     slot_i,
  input  logic [rtlpm_pkg::CntW-1:0]     count_i,
  input  rtlpm_pkg::wr_t                 wr_i,
  input  rtlpm_pkg::tok_t                tok_i,
  output rtlpm_pkg::tok_t                tok_o
);
  import rtlpm_pkg::*;

  route_t entry_q;
  tok_t   tok_d;
  tok_t   tok_q;
  logic   vld_q;
  logic   live;
  logic   is_last;
  logic   lk_hit;
  logic   dl_hit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == slot_i)) begin
      entry_q <= wr_i.data;
    end
  end

  always_comb begin
    live    = CntW'(slot_i) < count_i;
    is_last = live && ((CntW'(slot_i) + CntW'(1)) == count_i);
    lk_hit  = live && ((tok_i.key_addr & entry_q.mask) == entry_q.network) &&
              (entry_q.mask >= tok_i.data.mask);
    dl_hit  = live && !tok_i.found && (entry_q.network == tok_i.key_addr) &&
              (entry_q.mask == tok_i.key_mask);
    tok_d = tok_i;
    if (tok_i.lookup) begin
      if (lk_hit) begin
        tok_d.found = 1'b1;
        tok_d.data  = entry_q;
      end
    end else begin
      if (dl_hit) begin
        tok_d.found = 1'b1;
        tok_d.idx   = slot_i;
      end
      if (is_last) begin
        tok_d.data = entry_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = vld_q;
  end

endmodule

>>> rtl/route_table_longest_prefix_match.sv
// Top level of the route table engine: request control and the row of route cells.
//
// Each route lives in its own cell of a row of TableDepth cells. An add writes
// the slot at the current entry count and is answered through the emit state
// and the output register. A delete or lookup sends a search token down the
// row, one cell per cycle; the token keeps the best match (largest mask, later
// slot on ties) or the first exact match and the last entry, so these requests
// pass through every cell of the row before their result is taken. A delete
// then moves the captured last entry into the matched slot. One request is in
// flight at a time; a finished result waits in the output register while the
// next request is taken.
module route_table_longest_prefix_match (
  input logic          clk_i,
  input logic          rst_ni,
  rtlpm_req_if.sink    req_i,
  rtlpm_rsp_if.source  rsp_o
);
  import rtlpm_pkg::*;

  fsm_e                state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  status_e             st_q, st_d;
  route_t              res_q, res_d;
  logic                out_vld_q;
  status_e             out_st_q;
  route_t              out_res_q;
  logic                load_out;
  logic                accept;
  wr_t                 wr;
  tok_t                tok_in;
  tok_t                tok [TableDepth];
  tok_t                tail;
  logic [TableDepth-1:0] tok_vld;

  assign req_i.ready = (state_q == FsmIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign tail        = tok[TableDepth-1];

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    if (g == 0) begin : g_head
      rtlpm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .slot_i  (IdxW'(g)),
        .count_i (count_q),
        .wr_i    (wr),
        .tok_i   (tok_in),
        .tok_o   (tok[g])
      );
    end else begin : g_body
      rtlpm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .slot_i  (IdxW'(g)),
        .count_i (count_q),
        .wr_i    (wr),
        .tok_i   (tok[g-1]),
        .tok_o   (tok[g])
      );
    end
    assign tok_vld[g] = tok[g].valid;
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    st_d     = st_q;
    res_d    = res_q;
    load_out = 1'b0;
    wr       = '0;
    tok_in   = '0;
    unique case (state_q)
      FsmIdle: begin
        if (accept) begin
          unique case (req_e'(req_i.req_type))
            ReqAdd: begin
              res_d   = '0;
              state_d = FsmEmit;
              if (count_q == CntW'(TableDepth)) begin
                st_d = StFull;
              end else begin
                wr.en           = 1'b1;
                wr.idx          = count_q[IdxW-1:0];
                wr.data.network = req_i.dest_address & req_i.prefix_mask;
                wr.data.mask    = req_i.prefix_mask;
                wr.data.gateway = req_i.next_hop;
                wr.data.iface   = req_i.iface_id;
                wr.data.metric  = req_i.metric;
                count_d         = count_q + CntW'(1);
                st_d            = StOk;
              end
            end
            ReqDelete: begin
              tok_in.valid    = 1'b1;
              tok_in.lookup   = 1'b0;
              tok_in.key_addr = req_i.dest_address & req_i.prefix_mask;
              tok_in.key_mask = req_i.prefix_mask;
              state_d         = FsmSweep;
            end
            ReqLookup: begin
              tok_in.valid    = 1'b1;
              tok_in.lookup   = 1'b1;
              tok_in.key_addr = req_i.dest_address;
              state_d         = FsmSweep;
            end
            default: begin
              st_d    = StNoRoute;
              res_d   = '0;
              state_d = FsmEmit;
            end
          endcase
        end
      end
      FsmSweep: begin
        if (tail.valid) begin
          state_d = FsmEmit;
          res_d   = '0;
          if (tail.lookup) begin
            if (tail.found) begin
              st_d  = StOk;
              res_d = tail.data;
            end else begin
              st_d = StNoRoute;
            end
          end else if (tail.found) begin
            wr.en   = 1'b1;
            wr.idx  = tail.idx;
            wr.data = tail.data;
            count_d = count_q - CntW'(1);
            st_d    = StOk;
          end else begin
            st_d = StNotFound;
          end
        end
      end
      FsmEmit: begin
        if (!out_vld_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = FsmIdle;
        end
      end
      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FsmIdle;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    res_q <= res_d;
    if (load_out) begin
      out_st_q  <= st_q;
      out_res_q <= res_q;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.hit_network = out_res_q.network;
  assign rsp_o.hit_mask    = out_res_q.mask;
  assign rsp_o.hit_gateway = out_res_q.gateway;
  assign rsp_o.hit_iface   = out_res_q.iface;
  assign rsp_o.hit_metric  = out_res_q.metric;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count above table depth");

  a_single_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one search item in the cell row");

  a_tail_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> state_q == FsmSweep)
    else $error("search item left the row outside a sweep");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == ReqAdd) && (count_q != CntW'(TableDepth))
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("add did not grow the table");

  a_delete_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FsmSweep) && tail.valid && !tail.lookup && tail.found
    |=> count_q == $past(count_q) - CntW'(1))
    else $error("delete hit did not shrink the table");

endmodule
